FILE: rtl/fpwc_pkg.sv
// ----------------------------------------------------------------------------
// fpwc_pkg
// Shared types, sizes and codes of the flash page write combiner.
// ----------------------------------------------------------------------------
package fpwc_pkg;

  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 4096;
  localparam int REGION_BYTES = 131072;
  localparam int WORD_BYTES   = 8;

  localparam int KIND_W   = 2;
  localparam int SECNUM_W = 5;
  localparam int OFFSET_W = 12;
  localparam int DATA_W   = 8;
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 24;
  localparam int WORD_W   = WORD_BYTES * DATA_W;

  localparam int PAGE_W   = $clog2(PAGE_BYTES);
  localparam int SEC_W    = $clog2(SECTOR_BYTES);
  localparam int REG_W    = $clog2(REGION_BYTES);
  localparam int LANE_W   = $clog2(WORD_BYTES);
  localparam int ROWS     = PAGE_BYTES / WORD_BYTES;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int PNUM_W   = REG_W - PAGE_W;
  localparam int SUM_W    = SECNUM_W + SEC_W + 1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 96;

  localparam logic [ADDR_W-1:0] REGION_BASE_RST = 24'hFE0000;

  localparam logic [KIND_W-1:0] KIND_PROG      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERASE_SEC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERASE_REG = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SYNC      = 2'd3;

  localparam logic [CMD_W-1:0] CMD_DONE      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROG      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE_SEC = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE_REG = 2'd3;

  typedef struct packed {
    logic             capture;
    logic             rd_en;
    logic             rd_flush;
    logic             wr_en;
    logic             open_page;
    logic             clr_page;
    logic             load_word;
    logic             load_fin;
    logic [ROW_W-1:0] row;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              pending;
    logic              hit;
    logic              out_free;
  } dp_sts_t;

endpackage

FILE: rtl/flash_page_write_combiner_top.sv
// ----------------------------------------------------------------------------
// flash_page_write_combiner_top
// Combines byte program requests into one open flash page and emits program
// words, erase commands and a final result for every item.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata (low bit up)                          tuser / tlast
// in_       slave      sector[4:0] byte_offset[16:5] data[24:17]   tuser kind
// out_      master     command[1:0] flash_address[25:2] word[89:26] tlast last
// cfg_      write      region_base[23:0]                           none
//
// A byte program to the open page passes decode, read, write and finish, where
// its result is registered, before the next item is taken; a new page adds an
// open state. A flush reads and loads each of the 32 program words of a page,
// bounded by the single page RAM read port and the one result register.
// A sink stall holds the sequencer; one item is worked on at a time.
// Reset closes the page; the page RAM itself needs no clearing.
// ----------------------------------------------------------------------------
module flash_page_write_combiner_top
  import fpwc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sector, byte_offset, data
  input  logic [KIND_W-1:0]     in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // command, flash_address, word
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [ADDR_W-1:0]     cfg_wr_data
);

  localparam int SEC_LO  = 0;
  localparam int OFF_LO  = SEC_LO + SECNUM_W;
  localparam int DAT_LO  = OFF_LO + OFFSET_W;
  localparam int ADDR_LO = CMD_W;
  localparam int WORD_LO = ADDR_LO + ADDR_W;
  localparam int PAD_W   = OUT_DATA_W - WORD_LO - WORD_W;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [CMD_W-1:0]  out_command;
  logic [ADDR_W-1:0] out_address;
  logic [WORD_W-1:0] out_word;

  fpwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpwc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_kind     (in_tuser),
    .in_sector   (in_tdata[SEC_LO +: SECNUM_W]),
    .in_offset   (in_tdata[OFF_LO +: OFFSET_W]),
    .in_data     (in_tdata[DAT_LO +: DATA_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_command (out_command),
    .out_address (out_address),
    .out_word    (out_word)
  );

  assign out_tdata = {{PAD_W{1'b0}}, out_word, out_address, out_command};
  assign out_tlast = 1'b1 ^ (out_command == CMD_PROG);

endmodule

FILE: rtl/fpwc_ram.sv
// ----------------------------------------------------------------------------
// fpwc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fpwc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/fpwc_datapath.sv
// ----------------------------------------------------------------------------
// fpwc_datapath
// Page buffer, open page state, address arithmetic and the result register.
// ----------------------------------------------------------------------------
module fpwc_datapath
  import fpwc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [SECNUM_W-1:0]   in_sector,
  input  logic [OFFSET_W-1:0]   in_offset,
  input  logic [DATA_W-1:0]     in_data,
  input  logic                  cfg_wr_en,
  input  logic [ADDR_W-1:0]     cfg_wr_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [CMD_W-1:0]      out_command,
  output logic [ADDR_W-1:0]     out_address,
  output logic [WORD_W-1:0]     out_word
);

  logic [KIND_W-1:0]  kind_r;
  logic [REG_W-1:0]   byte_r;
  logic [REG_W-1:0]   sec_off_r;
  logic [DATA_W-1:0]  data_r;
  logic [PNUM_W-1:0]  open_page_r;
  logic               pending_r;
  logic [ROWS-1:0]    row_ok_r;
  logic [ADDR_W-1:0]  region_base_r;
  logic               out_vld_r;
  logic [CMD_W-1:0]   out_cmd_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [WORD_W-1:0]  out_word_r;

  logic [REG_W-1:0]   in_byte;
  logic [REG_W-1:0]   in_sec_off;
  logic [PNUM_W-1:0]  item_page;
  logic [ROW_W-1:0]   item_row;
  logic [LANE_W-1:0]  item_lane;
  logic [ROW_W-1:0]   rd_row;
  logic [ROW_W-1:0]   cur_row;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  old_word;
  logic [WORD_W-1:0]  merged;
  logic [REG_W-1:0]   flush_off;
  logic               out_free;

  assign in_byte    = REG_W'((SUM_W'(in_sector) << SEC_W) + SUM_W'(in_offset));
  assign in_sec_off = REG_W'(SUM_W'(in_sector) << SEC_W);
  assign item_page  = byte_r[REG_W-1:PAGE_W];
  assign item_row   = byte_r[PAGE_W-1:LANE_W];
  assign item_lane  = byte_r[LANE_W-1:0];
  assign rd_row     = cmd.rd_flush ? cmd.row : item_row;
  assign cur_row    = cmd.load_word ? cmd.row : item_row;
  assign old_word   = row_ok_r[cur_row] ? rd_data : {WORD_W{1'b1}};
  assign flush_off  = {open_page_r, cmd.row, {LANE_W{1'b0}}};
  assign out_free   = !out_vld_r || out_ready;

  always_comb begin
    for (int l = 0; l < WORD_BYTES; l++) begin
      if (item_lane == LANE_W'(l)) begin
        merged[l*DATA_W +: DATA_W] = old_word[l*DATA_W +: DATA_W] & data_r;
      end else begin
        merged[l*DATA_W +: DATA_W] = old_word[l*DATA_W +: DATA_W];
      end
    end
  end

  fpwc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_page_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (item_row),
    .wr_data (merged),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_row),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r    <= in_kind;
      byte_r    <= in_byte;
      sec_off_r <= in_sec_off;
      data_r    <= in_data;
    end
    if (cmd.load_word) begin
      out_cmd_r  <= CMD_PROG;
      out_addr_r <= ADDR_W'(region_base_r + ADDR_W'(flush_off));
      out_word_r <= old_word;
    end else if (cmd.load_fin) begin
      out_word_r <= '0;
      case (kind_r)
        KIND_ERASE_SEC: begin
          out_cmd_r  <= CMD_ERASE_SEC;
          out_addr_r <= ADDR_W'(region_base_r + ADDR_W'(sec_off_r));
        end
        KIND_ERASE_REG: begin
          out_cmd_r  <= CMD_ERASE_REG;
          out_addr_r <= region_base_r;
        end
        default: begin
          out_cmd_r  <= CMD_DONE;
          out_addr_r <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_page_r   <= '0;
      pending_r     <= 1'b0;
      row_ok_r      <= '0;
      region_base_r <= REGION_BASE_RST;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        region_base_r <= cfg_wr_data;
      end
      if (cmd.clr_page) begin
        open_page_r <= '0;
        pending_r   <= 1'b0;
      end else if (cmd.open_page) begin
        open_page_r <= item_page;
        row_ok_r    <= '0;
      end else if (cmd.wr_en) begin
        row_ok_r[item_row] <= 1'b1;
        pending_r          <= 1'b1;
      end
      if (cmd.load_word || cmd.load_fin) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign sts.kind     = kind_r;
  assign sts.pending  = pending_r;
  assign sts.hit      = pending_r && (item_page == open_page_r);
  assign sts.out_free = out_free;

  assign out_valid   = out_vld_r;
  assign out_command = out_cmd_r;
  assign out_address = out_addr_r;
  assign out_word    = out_word_r;

endmodule

FILE: rtl/fpwc_ctrl.sv
// ----------------------------------------------------------------------------
// fpwc_ctrl
// Sequencer for item decode, page flush, byte merge and the final result.
// ----------------------------------------------------------------------------
module fpwc_ctrl
  import fpwc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_FL_RD  = 4'd2;
  localparam logic [3:0] ST_FL_LD  = 4'd3;
  localparam logic [3:0] ST_FL_END = 4'd4;
  localparam logic [3:0] ST_OPEN   = 4'd5;
  localparam logic [3:0] ST_RMW_RD = 4'd6;
  localparam logic [3:0] ST_RMW_WR = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;

  logic [3:0]       state_r;
  logic [3:0]       state_nxt;
  logic [ROW_W-1:0] cnt_r;
  logic [ROW_W-1:0] cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.row   = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cnt_nxt = '0;
        case (sts.kind)
          KIND_PROG: begin
            if (sts.hit) begin
              state_nxt = ST_RMW_RD;
            end else if (sts.pending) begin
              state_nxt = ST_FL_RD;
            end else begin
              state_nxt = ST_OPEN;
            end
          end
          KIND_ERASE_REG: begin
            cmd.clr_page = 1'b1;
            state_nxt    = ST_FIN;
          end
          default: begin
            state_nxt = sts.pending ? ST_FL_RD : ST_FIN;
          end
        endcase
      end
      ST_FL_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_flush = 1'b1;
        state_nxt    = ST_FL_LD;
      end
      ST_FL_LD: begin
        if (sts.out_free) begin
          cmd.load_word = 1'b1;
          cnt_nxt       = cnt_r + ROW_W'(1);
          state_nxt     = (cnt_r == ROW_W'(ROWS - 1)) ? ST_FL_END : ST_FL_RD;
        end
      end
      ST_FL_END: begin
        cmd.clr_page = 1'b1;
        state_nxt    = (sts.kind == KIND_PROG) ? ST_OPEN : ST_FIN;
      end
      ST_OPEN: begin
        cmd.open_page = 1'b1;
        state_nxt     = ST_RMW_RD;
      end
      ST_RMW_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        cmd.wr_en = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_fin = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench of the flash page write combiner. Program, erase and sync
// items are driven with random gaps, results are taken with random stalls,
// and every result is compared field by field with a page buffer predictor
// that runs in step with the accepted items, under several region bases.
// ----------------------------------------------------------------------------
module tb
  import fpwc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [SECNUM_W-1:0] sector;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   data;
  } flash_req_t;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] word;
    logic              last;
  } flash_op_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [ADDR_W-1:0]     cfg_wr_data = '0;

  flash_req_t pending_reqs[$];
  flash_op_t  flash_ops_due[$];
  flash_req_t offered_req;

  logic [DATA_W-1:0] page_img [PAGE_BYTES];
  logic [PNUM_W-1:0] cur_page = '0;
  bit                img_pending = 1'b0;
  logic [ADDR_W-1:0] region_base_m = REGION_BASE_RST;

  int errors = 0;
  int cycles = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  logic [SECNUM_W-1:0] near_sector = '0;
  logic [3:0]          near_page = '0;

  flash_page_write_combiner_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic add_op(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                        input logic [WORD_W-1:0] word, input logic last);
    flash_op_t op;
    op.command = cmd;
    op.address = addr;
    op.word    = word;
    op.last    = last;
    flash_ops_due.push_back(op);
  endtask

  task automatic flush_page_ops();
    logic [WORD_W-1:0] w;
    logic [ADDR_W-1:0] a;
    if (img_pending) begin
      for (int row = 0; row < ROWS; row++) begin
        for (int b = 0; b < WORD_BYTES; b++)
          w[DATA_W*b +: DATA_W] = page_img[row*WORD_BYTES + b];
        a = ADDR_W'(region_base_m + ADDR_W'(cur_page) * PAGE_BYTES
                    + ADDR_W'(row * WORD_BYTES));
        add_op(CMD_PROG, a, w, 1'b0);
      end
      img_pending = 1'b0;
      cur_page = '0;
    end
  endtask

  task automatic model_flash_ops(input flash_req_t r);
    logic [REG_W-1:0]  roff;
    logic [PNUM_W-1:0] pg;
    logic [PAGE_W-1:0] idx;
    roff = REG_W'({r.sector, r.offset});
    pg   = roff[REG_W-1:PAGE_W];
    idx  = roff[PAGE_W-1:0];
    case (r.kind)
      KIND_PROG: begin
        if (!img_pending || pg != cur_page) begin
          flush_page_ops();
          foreach (page_img[i]) page_img[i] = 8'hFF;
          cur_page = pg;
        end
        page_img[idx] = page_img[idx] & r.data;
        img_pending = 1'b1;
        add_op(CMD_DONE, '0, '0, 1'b1);
      end
      KIND_ERASE_SEC: begin
        flush_page_ops();
        add_op(CMD_ERASE_SEC, region_base_m + ADDR_W'(REG_W'({r.sector, 12'd0})), '0, 1'b1);
      end
      KIND_ERASE_REG: begin
        img_pending = 1'b0;
        cur_page = '0;
        add_op(CMD_ERASE_REG, region_base_m, '0, 1'b1);
      end
      default: begin
        flush_page_ops();
        add_op(CMD_DONE, '0, '0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin : drive_requests
    bit go;
    go = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready)
        model_flash_ops(offered_req);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() != 0) begin
          if ($urandom_range(99) < in_idle_pct) begin
            in_gap = $urandom_range(8, 1) - 1;
          end else begin
            offered_req = pending_reqs.pop_front();
            go = 1'b1;
          end
        end
        in_tvalid <= go;
        if (go) begin
          in_tdata <= {7'd0, offered_req.data, offered_req.offset, offered_req.sector};
          in_tuser <= offered_req.kind;
        end
      end
    end
  end

  always @(posedge clk) begin : sink_results
    flash_op_t op;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (flash_ops_due.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          op = flash_ops_due.pop_front();
          if (out_tdata[1:0] !== op.command)
            report_mismatch($sformatf("command %0d, expected %0d", out_tdata[1:0], op.command));
          if (out_tdata[25:2] !== op.address)
            report_mismatch($sformatf("address %h, expected %h", out_tdata[25:2], op.address));
          if (out_tdata[89:26] !== op.word)
            report_mismatch($sformatf("word %h, expected %h", out_tdata[89:26], op.word));
          if (out_tlast !== op.last)
            report_mismatch($sformatf("last %b, expected %b", out_tlast, op.last));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < out_idle_pct) begin
        out_gap = $urandom_range(7, 0);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic [KIND_W-1:0] kind, input logic [SECNUM_W-1:0] sector,
                           input logic [OFFSET_W-1:0] offset, input logic [DATA_W-1:0] data);
    flash_req_t r;
    r.kind   = kind;
    r.sector = sector;
    r.offset = offset;
    r.data   = data;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || flash_ops_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_region_base(input logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    region_base_m = value;
  endtask

  // Mostly bursts of byte programs into one page, with page changes, syncs and erases.
  task automatic queue_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        if ($urandom_range(3) == 0) begin
          near_sector = SECNUM_W'($urandom_range(31));
          near_page   = 4'($urandom_range(15));
        end
        queue_req(KIND_PROG, near_sector, {near_page, 8'($urandom_range(255))},
                  ($urandom_range(4) == 0) ? 8'hFF : 8'($urandom_range(255)));
      end else begin
        queue_req((pick < 88) ? KIND_SYNC : (pick < 94) ? KIND_ERASE_SEC : KIND_ERASE_REG,
                  SECNUM_W'($urandom_range(31)), OFFSET_W'($urandom_range(4095)),
                  DATA_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    foreach (page_img[i]) page_img[i] = 8'hFF;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct  = 25;
    out_idle_pct = 25;

    queue_req(KIND_SYNC,      5'd0,  12'd0,    8'h00);
    queue_req(KIND_PROG,      5'd0,  12'd0,    8'h00);
    queue_req(KIND_PROG,      5'd0,  12'h0FF,  8'hA5);
    queue_req(KIND_PROG,      5'd0,  12'h0FF,  8'h5A);
    queue_req(KIND_PROG,      5'd31, 12'hFFF,  8'h7E);
    queue_req(KIND_SYNC,      5'd31, 12'hFFF,  8'hFF);
    queue_req(KIND_SYNC,      5'd0,  12'd0,    8'h00);
    queue_req(KIND_PROG,      5'd31, 12'hFFF,  8'h81);
    queue_req(KIND_ERASE_SEC, 5'd31, 12'hFFF,  8'hFF);
    queue_req(KIND_PROG,      5'd5,  12'h123,  8'h3C);
    queue_req(KIND_ERASE_REG, 5'd31, 12'hFFF,  8'hFF);
    queue_req(KIND_SYNC,      5'd0,  12'd0,    8'h00);
    queue_req(KIND_ERASE_SEC, 5'd0,  12'd0,    8'h00);
    wait_idle();

    set_region_base(24'hFFFFFF);
    queue_req(KIND_PROG,      5'd31, 12'hFFF,  8'h00);
    queue_req(KIND_PROG,      5'd31, 12'hF00,  8'hFE);
    queue_req(KIND_SYNC,      5'd0,  12'd0,    8'h00);
    queue_req(KIND_PROG,      5'd0,  12'd0,    8'h01);
    queue_req(KIND_ERASE_SEC, 5'd31, 12'd0,    8'h00);
    queue_req(KIND_ERASE_REG, 5'd0,  12'd0,    8'h00);
    wait_idle();

    set_region_base(24'h000000);
    queue_req(KIND_PROG,      5'd16, 12'h800,  8'h55);
    queue_req(KIND_PROG,      5'd16, 12'h900,  8'hAA);
    queue_req(KIND_ERASE_SEC, 5'd16, 12'h800,  8'h00);
    queue_req(KIND_ERASE_REG, 5'd1,  12'h001,  8'h01);
    wait_idle();

    set_region_base(24'($urandom()));
    in_idle_pct  = 30;
    out_idle_pct = 30;
    queue_random(112);
    wait_idle();

    set_region_base(24'hFFF800);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    queue_random(112);
    wait_idle();

    set_region_base(24'($urandom()));
    in_idle_pct  = 50;
    out_idle_pct = 50;
    queue_random(112);
    wait_idle();

    set_region_base(24'($urandom()));
    in_idle_pct  = 0;
    out_idle_pct = 0;
    queue_random(112);
    wait_idle();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
